/* design/lcgpt_pkg.sv */
package lcgpt_pkg;

   localparam int VALUE_WIDTH    = 16;
   localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(PROD_WIDTH);
   localparam int REQ_DATA_WIDTH = ((4 * VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((2 * VALUE_WIDTH + 7) / 8) * 8;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // operand register that a generator step reads and writes back
   typedef enum logic [1:0] {
      SRC_CUR   = 2'd0,
      SRC_LEAD  = 2'd1,
      SRC_TRAIL = 2'd2
   } src_type;

   typedef struct packed {
      logic    load;
      logic    step_start;
      src_type src;
      logic    cnt_inc;
      logic    cnt_clr;
      logic    mark_save;
      logic    period_save;
      logic    tail_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic step_done;
      logic cnt_eq_mod;
      logic cnt_eq_period;
      logic cur_eq_mark;
      logic lead_eq_trail;
   } dp_status_type;

endpackage

/* design/lcgpt_step.sv */
// One generator step: result = (mul * x + inc) mod modulus.
// Multiply, add, then restoring remainder one dividend bit per cycle.
module lcgpt_step
   import lcgpt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  value_type x_in,
   input  value_type mul,
   input  value_type inc,
   input  value_type modulus,
   output logic      done,
   output value_type result
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADD  = 3'b010,
      ST_DIV  = 3'b100
   } step_state_type;

   step_state_type           state_ff, state_in;
   logic [PROD_WIDTH-1:0]    prod_ff, prod_in;
   value_type                rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   value_type                result_ff, result_in;

   logic [VALUE_WIDTH:0]     rem_shift;
   logic [VALUE_WIDTH:0]     rem_sub;
   value_type                rem_next;

   assign rem_shift = {rem_ff, prod_ff[PROD_WIDTH-1]};
   assign rem_sub   = rem_shift - {1'b0, modulus};
   assign rem_next  = (rem_shift >= {1'b0, modulus}) ? rem_sub[VALUE_WIDTH-1:0]
                                                     : rem_shift[VALUE_WIDTH-1:0];

   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               prod_in  = PROD_WIDTH'(mul) * PROD_WIDTH'(x_in);
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            prod_in  = prod_ff + PROD_WIDTH'(inc);
            rem_in   = '0;
            cnt_in   = DIV_CNT_WIDTH'(PROD_WIDTH - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_next;
            prod_in = {prod_ff[PROD_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in   = 1'b1;
               result_in = rem_next;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* design/lcgpt_dp.sv */
// Job registers, walk pointers, counters and the shared step unit.
module lcgpt_dp
   import lcgpt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  value_type     req_multiplier,
   input  value_type     req_increment,
   input  value_type     req_modulus,
   input  value_type     req_seed,
   output dp_status_type status,
   output value_type     period,
   output value_type     tail_length,
   output logic          error
);

   value_type mul_ff, mul_in;
   value_type inc_ff, inc_in;
   value_type mod_ff, mod_in;
   value_type cur_ff, cur_in;
   value_type mark_ff, mark_in;
   value_type lead_ff, lead_in;
   value_type trail_ff, trail_in;
   value_type cnt_ff, cnt_in;
   value_type period_ff, period_in;
   value_type tail_ff, tail_in;
   logic      err_ff, err_in;
   src_type   src_ff, src_in;

   value_type step_x;
   logic      step_done;
   value_type step_result;

   always_comb begin
      case (cmd.src)
         SRC_CUR:   step_x = cur_ff;
         SRC_LEAD:  step_x = lead_ff;
         SRC_TRAIL: step_x = trail_ff;
         default:   step_x = cur_ff;
      endcase
   end

   lcgpt_step u_step (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.step_start),
      .x_in    (step_x),
      .mul     (mul_ff),
      .inc     (inc_ff),
      .modulus (mod_ff),
      .done    (step_done),
      .result  (step_result)
   );

   always_comb begin
      mul_in    = mul_ff;
      inc_in    = inc_ff;
      mod_in    = mod_ff;
      cur_in    = cur_ff;
      mark_in   = mark_ff;
      lead_in   = lead_ff;
      trail_in  = trail_ff;
      cnt_in    = cnt_ff;
      period_in = period_ff;
      tail_in   = tail_ff;
      err_in    = err_ff;
      src_in    = src_ff;

      if (cmd.load) begin
         mul_in    = req_multiplier;
         inc_in    = req_increment;
         mod_in    = req_modulus;
         cur_in    = req_seed;
         lead_in   = req_seed;
         trail_in  = req_seed;
         cnt_in    = '0;
         period_in = '0;
         tail_in   = '0;
         err_in    = (req_modulus == '0);
      end

      if (cmd.step_start) begin
         src_in = cmd.src;
      end

      // write the step result back to the register it came from
      if (step_done) begin
         case (src_ff)
            SRC_CUR:   cur_in   = step_result;
            SRC_LEAD:  lead_in  = step_result;
            SRC_TRAIL: trail_in = step_result;
            default:   cur_in   = step_result;
         endcase
      end

      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.mark_save) begin
         mark_in = cur_ff;
      end
      if (cmd.period_save) begin
         period_in = cnt_ff;
      end
      if (cmd.tail_inc) begin
         tail_in = tail_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= 1'b0;
         src_ff <= SRC_CUR;
      end else begin
         err_ff <= err_in;
         src_ff <= src_in;
      end
      mul_ff    <= mul_in;
      inc_ff    <= inc_in;
      mod_ff    <= mod_in;
      cur_ff    <= cur_in;
      mark_ff   <= mark_in;
      lead_ff   <= lead_in;
      trail_ff  <= trail_in;
      cnt_ff    <= cnt_in;
      period_ff <= period_in;
      tail_ff   <= tail_in;
   end

   assign status.mod_zero      = err_ff;
   assign status.step_done     = step_done;
   assign status.cnt_eq_mod    = (cnt_ff == mod_ff);
   assign status.cnt_eq_period = (cnt_ff == period_ff);
   assign status.cur_eq_mark   = (cur_ff == mark_ff);
   assign status.lead_eq_trail = (lead_ff == trail_ff);

   assign period      = period_ff;
   assign tail_length = tail_ff;
   assign error       = err_ff;

endmodule

/* design/lcgpt_ctrl.sv */
// Sequencer for the four walks: warm-up, cycle measure, lead offset, tail.
module lcgpt_ctrl
   import lcgpt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          out_free,
   output logic          out_load,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [13:0] {
      S_IDLE            = 14'b00000000000001,
      S_CHECK           = 14'b00000000000010,
      S_WARM            = 14'b00000000000100,
      S_WARM_WAIT       = 14'b00000000001000,
      S_CYC_GO          = 14'b00000000010000,
      S_CYC_WAIT        = 14'b00000000100000,
      S_CYC_CHK         = 14'b00000001000000,
      S_LEAD            = 14'b00000010000000,
      S_LEAD_WAIT       = 14'b00000100000000,
      S_TAIL            = 14'b00001000000000,
      S_TAIL_LEAD_WAIT  = 14'b00010000000000,
      S_TAIL_TRAIL      = 14'b00100000000000,
      S_TAIL_TRAIL_WAIT = 14'b01000000000000,
      S_DONE            = 14'b10000000000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.src   = SRC_CUR;
      req_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = status.mod_zero ? S_DONE : S_WARM;
         end
         S_WARM: begin
            if (status.cnt_eq_mod) begin
               cmd.mark_save = 1'b1;
               cmd.cnt_clr   = 1'b1;
               state_in      = S_CYC_GO;
            end else begin
               cmd.step_start = 1'b1;
               cmd.cnt_inc    = 1'b1;
               state_in       = S_WARM_WAIT;
            end
         end
         S_WARM_WAIT: begin
            if (status.step_done) begin
               state_in = S_WARM;
            end
         end
         S_CYC_GO: begin
            cmd.step_start = 1'b1;
            cmd.cnt_inc    = 1'b1;
            state_in       = S_CYC_WAIT;
         end
         S_CYC_WAIT: begin
            if (status.step_done) begin
               state_in = S_CYC_CHK;
            end
         end
         S_CYC_CHK: begin
            if (status.cur_eq_mark) begin
               cmd.period_save = 1'b1;
               cmd.cnt_clr     = 1'b1;
               state_in        = S_LEAD;
            end else begin
               state_in = S_CYC_GO;
            end
         end
         S_LEAD: begin
            if (status.cnt_eq_period) begin
               state_in = S_TAIL;
            end else begin
               cmd.step_start = 1'b1;
               cmd.src        = SRC_LEAD;
               cmd.cnt_inc    = 1'b1;
               state_in       = S_LEAD_WAIT;
            end
         end
         S_LEAD_WAIT: begin
            if (status.step_done) begin
               state_in = S_LEAD;
            end
         end
         S_TAIL: begin
            if (status.lead_eq_trail) begin
               state_in = S_DONE;
            end else begin
               cmd.step_start = 1'b1;
               cmd.src        = SRC_LEAD;
               cmd.tail_inc   = 1'b1;
               state_in       = S_TAIL_LEAD_WAIT;
            end
         end
         S_TAIL_LEAD_WAIT: begin
            if (status.step_done) begin
               state_in = S_TAIL_TRAIL;
            end
         end
         S_TAIL_TRAIL: begin
            cmd.step_start = 1'b1;
            cmd.src        = SRC_TRAIL;
            state_in       = S_TAIL_TRAIL_WAIT;
         end
         S_TAIL_TRAIL_WAIT: begin
            if (status.step_done) begin
               state_in = S_TAIL;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/lcg_period_and_tail_length_core.sv */
// Period and tail-length finder for a linear congruential generator
// x' = (a*x + b) mod c. Each request beat carries a, b, c and the seed; the
// block answers with one response beat holding the cycle length (period)
// and the number of values before the sequence enters that cycle
// (tail_length). A zero modulus is rejected at once: the response has
// error set in tuser and both counts zero. A seed at or above the modulus
// is used as is and counts toward the tail. One job is in flight at a
// time; a finished response waits in an output register, so a new request
// can be taken while the previous response is still pending. Every
// generator step runs on one shared step unit (a multiply, an add, then
// a restoring remainder at one bit per cycle over the 2*VALUE_WIDTH-bit
// product); a step of the cycle measure adds a compare state. A job takes
// (c + 2*period + 2*tail_length) steps; period plus tail_length is at most
// c+1, so at most about 3*c + 2 steps.
module lcg_period_and_tail_length_core
   import lcgpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [VW-1:0] multiplier, [2VW-1:VW] increment, [3VW-1:2VW] modulus,
   // [4VW-1:3VW] seed (VW = VALUE_WIDTH), zero padded to whole bytes
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [VW-1:0] period, [2VW-1:VW] tail_length, zero padded to whole bytes
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [0] error
   output logic                      rsp_tuser
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          out_free;
   logic          out_load;
   value_type     dp_period;
   value_type     dp_tail;
   logic          dp_error;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;

   // response slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   lcgpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .out_load  (out_load),
      .cmd       (cmd),
      .status    (status)
   );

   lcgpt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_multiplier (req_tdata[0*VALUE_WIDTH +: VALUE_WIDTH]),
      .req_increment  (req_tdata[1*VALUE_WIDTH +: VALUE_WIDTH]),
      .req_modulus    (req_tdata[2*VALUE_WIDTH +: VALUE_WIDTH]),
      .req_seed       (req_tdata[3*VALUE_WIDTH +: VALUE_WIDTH]),
      .status         (status),
      .period         (dp_period),
      .tail_length    (dp_tail),
      .error          (dp_error)
   );

   // output register: load the finished job, drop the beat once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_WIDTH'({dp_tail, dp_period});
         rsp_user_in  = dp_error;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* design/lcgpt_checker.sv */
module lcgpt_checker
   import lcgpt_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                      rsp_tuser
);

   // a pending response beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // only one job in flight: no request taken right after one is taken
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a job is running");

   // error responses carry zero counts
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error response with nonzero counts");

   // a valid generator always has a cycle of at least one value
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[VALUE_WIDTH-1:0] != '0)
      else $error("zero period without error");

   // reset empties the response slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind lcg_period_and_tail_length_core lcgpt_checker u_lcgpt_checker (.*);

/* bench/tb.sv */
module tb;
   import lcgpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one generator step on the shared unit, sequencer handoff included
   localparam int STEP_CYCLES = 2 * VALUE_WIDTH + 4;
   // receiver hold-off long enough for the job slot and the output register to fill
   localparam int LONG_HOLD   = 8000;

   typedef struct packed {
      value_type multiplier;
      value_type increment;
      value_type modulus;
      value_type seed;
   } lcg_job_type;

   typedef struct packed {
      value_type period;
      value_type tail_length;
      logic      error;
   } lcg_answer_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;

   lcg_answer_type pending_answers[$];
   int             fail_count   = 0;
   longint         cycle_count  = 0;
   // grows with every beat sent: the slowest correct run, before the safety factor
   longint         cycle_budget = 1000;
   bit             offer_held   = 1'b0;
   bit             req_quiet    = 1'b0;
   bit             rsp_quiet    = 1'b0;
   int             rsp_hold     = 0;

   lcg_period_and_tail_length_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one; quiet mode means no gap at all.
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic value_type lcg_advance(input lcg_job_type j, input longint unsigned x);
      longint unsigned prod;
      prod = longint'(j.multiplier) * x + longint'(j.increment);
      return value_type'(prod % longint'(j.modulus));
   endfunction

   // Expected period and tail length, found the same way the block walks the sequence:
   // settle onto the cycle, measure it, then run two pointers a period apart until they meet.
   function automatic lcg_answer_type compute_period_tail(input lcg_job_type j);
      lcg_answer_type  ans;
      longint unsigned cur, mark, span, tail, lead, trail, i;
      ans = '0;
      if (j.modulus == '0) begin
         ans.error = 1'b1;
         return ans;
      end
      cur = j.seed;
      for (i = 0; i < j.modulus; i++)
         cur = lcg_advance(j, cur);
      mark = cur;
      span = 0;
      do begin
         cur  = lcg_advance(j, cur);
         span = span + 1;
      end while (cur != mark);
      lead = j.seed;
      for (i = 0; i < span; i++)
         lead = lcg_advance(j, lead);
      trail = j.seed;
      tail  = 0;
      while (trail != lead) begin
         lead  = lcg_advance(j, lead);
         trail = lcg_advance(j, trail);
         tail  = tail + 1;
      end
      ans.period      = value_type'(span);
      ans.tail_length = value_type'(tail);
      return ans;
   endfunction

   function automatic lcg_job_type make_job(input value_type a, input value_type b,
                                            input value_type c, input value_type s);
      lcg_job_type j;
      j.multiplier = a;
      j.increment  = b;
      j.modulus    = c;
      j.seed       = s;
      return j;
   endfunction

   // Random job: full-width multiplier, increment and seed; the modulus is mostly small
   // so the run stays short, with zero moduli and full-period generators mixed in.
   function automatic lcg_job_type random_job();
      lcg_job_type j;
      int          r;
      j.multiplier = value_type'($urandom);
      j.increment  = value_type'($urandom);
      j.seed       = value_type'($urandom);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         j.modulus = '0;
      end else if (r < 23) begin
         // power-of-two modulus, odd increment, multiplier 1 mod 4: the period is the modulus
         j.modulus       = value_type'(1) << $urandom_range(1, 7);
         j.multiplier[1] = 1'b0;
         j.multiplier[0] = 1'b1;
         j.increment[0]  = 1'b1;
      end else if (r < 75) begin
         j.modulus = value_type'($urandom_range(1, 64));
      end else if (r < 97) begin
         j.modulus = value_type'($urandom_range(65, 400));
      end else begin
         j.modulus = value_type'($urandom_range(401, 1500));
      end
      // half of the seeds land below the modulus, the rest stay raw and mostly join the tail
      if (j.modulus != '0 && $urandom_range(0, 1) == 1)
         j.seed = j.seed % j.modulus;
      return j;
   endfunction

   // Offer one request beat and return at the edge that takes it. Valid stays high
   // after the handshake so the next beat can follow without a bubble.
   task automatic send_job(input lcg_job_type j);
      int gap;
      bit taken;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         if (offer_held)
            req_tvalid <= 1'b0;
         offer_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'({j.seed, j.modulus, j.increment, j.multiplier});
      offer_held = 1'b1;
      // sample ready mid-cycle; it holds until the next rising edge
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      pending_answers.push_back(compute_period_tail(j));
      cycle_budget += (5 * longint'(j.modulus) + 8) * STEP_CYCLES + 400;
   endtask

   // Drop valid and wait until every outstanding response beat has been checked.
   task automatic wait_for_drain();
      if (offer_held)
         req_tvalid <= 1'b0;
      offer_held = 1'b0;
      do
         @(posedge clock);
      while (pending_answers.size() != 0);
   endtask

   // Field extremes, zero modulus, modulus one, seeds at or above the modulus,
   // full period, and the largest modulus once with a trivial generator.
   task automatic test_directed_jobs();
      lcg_job_type jobs[$];
      jobs.push_back(make_job(16'd5,      16'd7,      16'd0,      16'd3));
      jobs.push_back(make_job(16'hFFFF,   16'hFFFF,   16'd0,      16'hFFFF));
      jobs.push_back(make_job(16'd0,      16'd0,      16'd1,      16'd0));
      jobs.push_back(make_job(16'hFFFF,   16'hFFFF,   16'd1,      16'hFFFF));
      jobs.push_back(make_job(16'd0,      16'd0,      16'd2,      16'd0));
      jobs.push_back(make_job(16'd1,      16'd1,      16'd16,     16'd0));
      jobs.push_back(make_job(16'd5,      16'd3,      16'd64,     16'd17));
      jobs.push_back(make_job(16'd3,      16'd1,      16'd10,     16'hFFFF));
      jobs.push_back(make_job(16'hFFFF,   16'hFFFF,   16'd251,    16'h1234));
      jobs.push_back(make_job(16'd2,      16'd0,      16'd12,     16'd1));
      jobs.push_back(make_job(16'd0,      16'd5,      16'd7,      16'd7));
      jobs.push_back(make_job(16'd1,      16'd0,      16'd9,      16'd9));
      jobs.push_back(make_job(16'hFFFF,   16'd0,      16'd13,     16'd0));
      // largest modulus: settling alone takes a step for every possible value, so keep the cycle trivial
      jobs.push_back(make_job(16'd0,      16'h1234,   16'hFFFF,   16'd0));
      foreach (jobs[i])
         send_job(jobs[i]);
      wait_for_drain();
   endtask

   // Receiver holds off while the sender keeps offering, so the job slot and the
   // output register fill and the request channel stalls.
   task automatic test_backpressure();
      req_quiet = 1'b1;
      rsp_hold  = LONG_HOLD;
      cycle_budget += LONG_HOLD;
      repeat (6)
         send_job(make_job(value_type'($urandom), value_type'($urandom),
                           value_type'($urandom_range(1, 6)), value_type'($urandom)));
      req_quiet = 1'b0;
      wait_for_drain();
   endtask

   // Both sides at full rate, no idling at all.
   task automatic test_back_to_back();
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      repeat (10)
         send_job(random_job());
      wait_for_drain();
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   // Bulk random jobs with gaps on both sides; pause for a full drain midway.
   task automatic test_random_jobs(input int count);
      for (int n = 0; n < count; n++) begin
         send_job(random_job());
         if (n == count / 2)
            wait_for_drain();
      end
      wait_for_drain();
   endtask

   // Receiver: random stalls, or the long hold-off when a test asks for one.
   initial begin : rsp_sink
      int stall;
      forever begin
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = pick_gap(rsp_quiet);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Check each response beat mid-cycle: valid and ready seen here are the values
   // at the coming rising edge, where the beat is taken.
   always @(negedge clock) begin
      lcg_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("response beat with nothing outstanding: tdata %h, tuser %b",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[VALUE_WIDTH-1:0] !== want.period) begin
               $error("period: expected %0d, got %0d", want.period,
                      rsp_tdata[VALUE_WIDTH-1:0]);
               fail_count++;
            end
            if (rsp_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH] !== want.tail_length) begin
               $error("tail_length: expected %0d, got %0d", want.tail_length,
                      rsp_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]);
               fail_count++;
            end
            if (rsp_tuser !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: the budget follows the slowest correct run, taken four times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4 * cycle_budget + 100000) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_jobs();
      test_backpressure();
      test_back_to_back();
      test_random_jobs(70);

      // let any stray beat show up before the verdict
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_answers.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
design/lcgpt_pkg.sv
design/lcgpt_step.sv
design/lcgpt_dp.sv
design/lcgpt_ctrl.sv
design/lcg_period_and_tail_length_core.sv
design/lcgpt_checker.sv
bench/tb.sv
